[rtl/core/qte_pkg.sv]
// Package for the quaternion to Euler angle block.
// Holds fixed-point widths, CORDIC constants and the angle output rounding.
// No dependencies.
`default_nettype none
package qte_pkg;
  localparam int LOAD_W = 18;
  localparam int PROD_W = 36;
  localparam int RW = 39;
  localparam int CW = 41;
  localparam int AW = 34;
  localparam int ROLL_W = 16;
  localparam int PITCH_W = 15;
  localparam int LO_W = 21;
  localparam int GAIN_W = 24;
  localparam logic [GAIN_W-1:0] INV_GAIN_Q24 = 24'd10188013;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [AW-1:0] PI_Q13_MAX = 34'sd25736;
  localparam logic signed [AW-1:0] HALF_PI_Q13_MAX = 34'sd12868;

  function automatic logic signed [AW-1:0] atan_q30(input int i);
    logic signed [AW-1:0] r;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ROLL_W-1:0] to_q13(input logic signed [AW-1:0] z,
                                                      input logic signed [AW-1:0] lim);
    logic signed [AW-1:0] t;
    t = (z + 34'sd65536) >>> 17;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t[ROLL_W-1:0];
  endfunction
endpackage
`default_nettype wire

[rtl/core/qte_if.sv]
// Stream interfaces for quaternion input and Euler angle output transactions.
// Depends on qte_pkg for the output widths.
`default_nettype none
interface qte_quat_if #(parameter int QUAT_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
  logic valid;
  logic ready;
  logic signed [qte_pkg::ROLL_W-1:0] roll_angle;
  logic signed [qte_pkg::PITCH_W-1:0] pitch_angle;
  logic signed [qte_pkg::ROLL_W-1:0] yaw_angle;
  modport source(output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface
`default_nettype wire

[rtl/core/qte_matrix.sv]
// Rotation matrix terms from a quaternion: input scaling, products, sums.
// Three register stages. Depends on qte_pkg.
`default_nettype none
module qte_matrix #(
  parameter int QUAT_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic signed [QUAT_WIDTH-1:0] w_in,
  input  wire logic signed [QUAT_WIDTH-1:0] x_in,
  input  wire logic signed [QUAT_WIDTH-1:0] y_in,
  input  wire logic signed [QUAT_WIDTH-1:0] z_in,
  output logic out_valid,
  output logic signed [qte_pkg::RW-1:0] r21,
  output logic signed [qte_pkg::RW-1:0] r22,
  output logic signed [qte_pkg::RW-1:0] r20,
  output logic signed [qte_pkg::RW-1:0] r10,
  output logic signed [qte_pkg::RW-1:0] r00
);
  import qte_pkg::*;

  logic signed [LOAD_W-1:0] w_l, x_l, y_l, z_l;
  logic signed [LOAD_W-1:0] w_r, x_r, y_r, z_r;
  logic signed [PROD_W-1:0] p_yz, p_wx, p_xx, p_yy, p_xz, p_wy, p_xy, p_wz, p_zz;
  logic [1:0] valid_s;

  if (QUAT_WIDTH > LOAD_W) begin : g_trunc
    assign w_l = w_in[QUAT_WIDTH-1 -: LOAD_W];
    assign x_l = x_in[QUAT_WIDTH-1 -: LOAD_W];
    assign y_l = y_in[QUAT_WIDTH-1 -: LOAD_W];
    assign z_l = z_in[QUAT_WIDTH-1 -: LOAD_W];
  end else begin : g_scale
    assign w_l = LOAD_W'(w_in) <<< (LOAD_W - QUAT_WIDTH);
    assign x_l = LOAD_W'(x_in) <<< (LOAD_W - QUAT_WIDTH);
    assign y_l = LOAD_W'(y_in) <<< (LOAD_W - QUAT_WIDTH);
    assign z_l = LOAD_W'(z_in) <<< (LOAD_W - QUAT_WIDTH);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_l;
      x_r <= x_l;
      y_r <= y_l;
      z_r <= z_l;
      p_yz <= y_r * z_r;
      p_wx <= w_r * x_r;
      p_xx <= x_r * x_r;
      p_yy <= y_r * y_r;
      p_xz <= x_r * z_r;
      p_wy <= w_r * y_r;
      p_xy <= x_r * y_r;
      p_wz <= w_r * z_r;
      p_zz <= z_r * z_r;
      r21 <= (RW'(p_yz) + RW'(p_wx)) <<< 1;
      r22 <= (RW'(1) <<< 32) - ((RW'(p_xx) + RW'(p_yy)) <<< 1);
      r20 <= (RW'(p_xz) - RW'(p_wy)) <<< 1;
      r10 <= (RW'(p_xy) + RW'(p_wz)) <<< 1;
      r00 <= (RW'(1) <<< 32) - ((RW'(p_yy) + RW'(p_zz)) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_s <= {valid_s[0], in_valid};
      out_valid <= valid_s[1];
    end
  end
endmodule
`default_nettype wire

[rtl/core/qte_cordic.sv]
// Pipelined vectoring CORDIC: quadrant pre-rotation stage, then one stage
// per iteration. Gives the angle in Q30 and the scaled magnitude. Depends on qte_pkg.
`default_nettype none
module qte_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic signed [qte_pkg::CW-1:0] x_in,
  input  wire logic signed [qte_pkg::CW-1:0] y_in,
  output logic out_valid,
  output logic signed [qte_pkg::AW-1:0] angle,
  output logic signed [qte_pkg::CW-1:0] mag
);
  import qte_pkg::*;

  logic signed [CW-1:0] x_s [0:STAGES];
  logic signed [CW-1:0] y_s [0:STAGES];
  logic signed [AW-1:0] z_s [0:STAGES];
  logic zero_s [0:STAGES];
  logic [STAGES:0] valid_s;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_s[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[CW-1] && !y_in[CW-1]) begin
        x_s[0] <= y_in;
        y_s[0] <= -x_in;
        z_s[0] <= HALF_PI_Q30;
      end else if (x_in[CW-1]) begin
        x_s[0] <= -y_in;
        y_s[0] <= x_in;
        z_s[0] <= -HALF_PI_Q30;
      end else begin
        x_s[0] <= x_in;
        y_s[0] <= y_in;
        z_s[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zero_s[i+1] <= zero_s[i];
        if (!y_s[i][CW-1]) begin
          x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] + atan_q30(i);
        end else begin
          x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] - atan_q30(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s <= '0;
    end else if (en) begin
      valid_s <= {valid_s[STAGES-1:0], in_valid};
    end
  end

  assign out_valid = valid_s[STAGES];
  assign angle = zero_s[STAGES] ? '0 : z_s[STAGES];
  assign mag = zero_s[STAGES] ? '0 : x_s[STAGES];
endmodule
`default_nettype wire

[rtl/core/qte_gain.sv]
// Removes the CORDIC gain from the magnitude: two partial products, then
// their sum shifted down by 24. Two register stages. Depends on qte_pkg.
`default_nettype none
module qte_gain (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic signed [qte_pkg::CW-1:0] mag,
  output logic out_valid,
  output logic signed [qte_pkg::CW-1:0] hyp
);
  import qte_pkg::*;

  localparam int PL_W = LO_W + GAIN_W;
  localparam int PH_W = CW - LO_W + GAIN_W + 1;
  localparam int SUM_W = CW + GAIN_W + 1;

  logic [PL_W-1:0] p_lo;
  logic signed [PH_W-1:0] p_hi;
  logic signed [SUM_W-1:0] sum;
  logic valid_1;

  assign sum = (SUM_W'(p_hi) <<< LO_W) + SUM_W'($signed({1'b0, p_lo}));

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo <= PL_W'(mag[LO_W-1:0]) * PL_W'(INV_GAIN_Q24);
      p_hi <= PH_W'($signed(mag[CW-1:LO_W])) * $signed(PH_W'(INV_GAIN_Q24));
      hyp <= sum[GAIN_W +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_1 <= in_valid;
      out_valid <= valid_1;
    end
  end
endmodule
`default_nettype wire

[rtl/core/quaternion_to_euler_angles.sv]
// Quaternion to Z-Y-X Euler angles (roll, pitch, yaw); roll and yaw in Q3.13 radians, pitch in Q2.13.
// Pipeline order: matrix terms, roll and yaw CORDIC in parallel, gain removal,
// pitch CORDIC, output register.
// Throughput is one transaction per cycle; a stall holds the whole pipeline.
// Synchronous reset clears all valid bits; data registers are not reset.
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = 16,
  parameter int QUAT_WIDTH = 16
) (
  input wire logic clk,
  input wire logic rst,
  qte_quat_if.sink quat,
  qte_euler_if.source euler
);
  import qte_pkg::*;

  localparam int DLY = CORDIC_STAGES + 3;

  logic en;
  logic m_valid, ry_valid, g_valid, p_valid, y_valid_unused;
  logic signed [RW-1:0] r21, r22, r20, r10, r00;
  logic signed [AW-1:0] roll_z, yaw_z, pitch_z;
  logic signed [CW-1:0] roll_mag, yaw_mag, pitch_mag, hyp;
  logic signed [AW-1:0] roll_d [0:DLY-1];
  logic signed [AW-1:0] yaw_d [0:DLY-1];
  logic signed [RW-1:0] r20_d [0:DLY-1];
  logic signed [ROLL_W-1:0] pitch_full;
  logic out_valid;

  assign en = !out_valid || euler.ready;
  assign quat.ready = en;

  qte_matrix #(.QUAT_WIDTH(QUAT_WIDTH)) u_matrix (
    .clk, .rst, .en, .in_valid(quat.valid),
    .w_in(quat.quat_w), .x_in(quat.quat_x), .y_in(quat.quat_y), .z_in(quat.quat_z),
    .out_valid(m_valid), .r21, .r22, .r20, .r10, .r00
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk, .rst, .en, .in_valid(m_valid), .x_in(CW'(r22)), .y_in(CW'(r21)),
    .out_valid(ry_valid), .angle(roll_z), .mag(roll_mag)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk, .rst, .en, .in_valid(m_valid), .x_in(CW'(r00)), .y_in(CW'(r10)),
    .out_valid(y_valid_unused), .angle(yaw_z), .mag(yaw_mag)
  );

  qte_gain u_gain (
    .clk, .rst, .en, .in_valid(ry_valid), .mag(roll_mag),
    .out_valid(g_valid), .hyp
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk, .rst, .en, .in_valid(g_valid), .x_in(hyp), .y_in(-CW'(r20_d[DLY-1])),
    .out_valid(p_valid), .angle(pitch_z), .mag(pitch_mag)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      r20_d[0] <= r20;
      roll_d[0] <= roll_z;
      yaw_d[0] <= yaw_z;
      for (int i = 1; i < DLY; i++) begin
        r20_d[i] <= r20_d[i-1];
        roll_d[i] <= roll_d[i-1];
        yaw_d[i] <= yaw_d[i-1];
      end
    end
  end

  assign pitch_full = to_q13(pitch_z, HALF_PI_Q13_MAX);

  always_ff @(posedge clk) begin
    if (en) begin
      euler.roll_angle <= to_q13(roll_d[DLY-1], PI_Q13_MAX);
      euler.pitch_angle <= pitch_full[PITCH_W-1:0];
      euler.yaw_angle <= to_q13(yaw_d[DLY-1], PI_Q13_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p_valid;
    end
  end

  assign euler.valid = out_valid;

  a_reset_clears: assert property (@(posedge clk) rst |=> !euler.valid)
    else $error("output valid after reset");
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    euler.valid && !euler.ready |-> !quat.ready)
    else $error("input taken while output stalled");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    euler.valid |-> (euler.pitch_angle <= 15'sd12868 && euler.pitch_angle >= -15'sd12868))
    else $error("pitch out of range");
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    euler.valid |-> (euler.roll_angle <= 16'sd25736 && euler.roll_angle >= -16'sd25736))
    else $error("roll out of range");
endmodule
`default_nettype wire
